// ===== rtl/multi_pattern_string_matcher_unit_assert.svh =====
// Assertion macros used by the checker file.
`ifndef MULTI_PATTERN_STRING_MATCHER_UNIT_ASSERT_SVH
`define MULTI_PATTERN_STRING_MATCHER_UNIT_ASSERT_SVH

// Clocked assertion that is switched off while reset is high.
`define MPSM_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Clocked assertion that also holds during reset.
`define MPSM_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// ===== rtl/mpsm_pkg.sv =====
package mpsm_pkg;

  // Input command codes.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INS_RD,
    ST_INS_DO,
    ST_RB_START,
    ST_RB_RD,
    ST_RB_CHK,
    ST_RB_PAR,
    ST_RB_NEXT,
    ST_GW_RD,
    ST_GW_CHK,
    ST_SR_START,
    ST_CH_TEST,
    ST_CH_CHK
  } state_t;

endpackage

// ===== rtl/mpsm_ram.sv =====
module mpsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/multi_pattern_string_matcher_unit.sv =====
// Aho-Corasick matcher. An insert transaction adds one pattern byte to the trie: ST_INS_RD
// reads the child table and ST_INS_DO registers the result. A search transaction steps
// the automaton by one text byte and reports the first terminal vertex on the suffix
// chain, following suffix links until a goto edge is found and then visiting the chain
// vertices. The first search after any insert first rebuilds all suffix links by depth,
// scanning every vertex once per trie level and walking the goto edges from the suffix
// link of each vertex's parent. After reset a clearing pass writes every entry of the
// child table before the first transaction is accepted. A result stays in the output
// register until taken; the next transaction can be accepted in the cycle after it is
// taken.
module multi_pattern_string_matcher_unit
  import mpsm_pkg::*;
#(
  parameter int MAX_VERTICES  = 256,
  parameter int SYMBOL_BITS   = 8,
  parameter int POSITION_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [7:0]  symbol,
  input  logic        pattern_end,
  input  logic        text_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        match_found,
  output logic [31:0] match_start,
  output logic [7:0]  pattern_number,
  output logic        table_full
);

  localparam int VB   = $clog2(MAX_VERTICES);
  localparam int SB   = SYMBOL_BITS;
  localparam int PB   = POSITION_BITS;
  localparam int CD   = MAX_VERTICES << SB;
  localparam int CAW  = VB + SB;
  localparam int VIW  = 2 * VB + SB + 9;
  localparam int EXTW = (PB > 32) ? PB : 32;

  state_t state, state_next;

  // Architectural registers.
  logic [VB:0]    vcount;
  logic [7:0]     pcount;
  logic [VB-1:0]  ins_v, ins_d, max_depth, sv;
  logic [PB-1:0]  pos;
  logic           memo_valid;

  // Working registers.
  logic [CAW-1:0] clr_addr;
  logic [SB-1:0]  sym_r, c;
  logic           pend_r, tstart_r, mode_search;
  logic [VB-1:0]  w, v, d, cv;

  // Memory ports.
  logic           ch_we, vi_we, sf_we;
  logic [CAW-1:0] ch_waddr, ch_raddr;
  logic [VB-1:0]  ch_wdata, ch_rdata;
  logic [VB-1:0]  vi_waddr, vi_raddr, sf_waddr, sf_raddr, sf_wdata, sf_rdata;
  logic [VIW-1:0] vi_wdata, vi_rdata;

  // Fields of the vertex record read back.
  logic [VB-1:0]  rd_depth, rd_parent;
  logic [SB-1:0]  rd_psym;
  logic           rd_term;
  logic [7:0]     rd_num;

  logic           accept, child_none, table_over;
  logic [7:0]     pcount_inc;
  logic [VB-1:0]  new_v, new_d, gw_res;
  logic [PB-1:0]  start_pos;
  logic [EXTW-1:0] start_ext;

  assign {rd_depth, rd_parent, rd_psym, rd_term, rd_num} = vi_rdata;

  assign accept     = in_valid && in_ready;
  assign in_ready   = (state == ST_IDLE) && !out_valid;
  assign child_none = (ch_rdata == '0);
  assign table_over = (vcount >= (VB+1)'(MAX_VERTICES));
  assign pcount_inc = (pcount < 8'd255) ? pcount + 8'd1 : pcount;
  assign new_v      = child_none ? vcount[VB-1:0] : ch_rdata;
  assign new_d      = ins_d + VB'(1);
  assign gw_res     = child_none ? '0 : ch_rdata;
  assign start_pos  = pos - PB'(rd_depth) + PB'(1);
  assign start_ext  = EXTW'(start_pos);

  mpsm_ram #(.WIDTH(VB), .DEPTH(CD)) u_child (
    .clk, .wr_en(ch_we), .wr_addr(ch_waddr), .wr_data(ch_wdata),
    .rd_addr(ch_raddr), .rd_data(ch_rdata)
  );

  mpsm_ram #(.WIDTH(VIW), .DEPTH(MAX_VERTICES)) u_vinfo (
    .clk, .wr_en(vi_we), .wr_addr(vi_waddr), .wr_data(vi_wdata),
    .rd_addr(vi_raddr), .rd_data(vi_rdata)
  );

  mpsm_ram #(.WIDTH(VB), .DEPTH(MAX_VERTICES)) u_suffix (
    .clk, .wr_en(sf_we), .wr_addr(sf_waddr), .wr_data(sf_wdata),
    .rd_addr(sf_raddr), .rd_data(sf_rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:    if (clr_addr == '1) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if (command == CMD_INSERT)  state_next = ST_INS_RD;
          else if (!memo_valid)       state_next = ST_RB_START;
          else                        state_next = ST_SR_START;
        end
      end
      ST_INS_RD:   state_next = ST_INS_DO;
      ST_INS_DO:   state_next = ST_IDLE;
      ST_RB_START: state_next = (max_depth == '0) ? ST_SR_START : ST_RB_RD;
      ST_RB_RD:    state_next = ST_RB_CHK;
      ST_RB_CHK: begin
        if (rd_depth != d || rd_parent == '0) state_next = ST_RB_NEXT;
        else                                  state_next = ST_RB_PAR;
      end
      ST_RB_PAR:   state_next = ST_GW_RD;
      ST_RB_NEXT: begin
        if ((VB+1)'(v) + (VB+1)'(1) == vcount && d == max_depth) begin
          state_next = ST_SR_START;
        end else begin
          state_next = ST_RB_RD;
        end
      end
      ST_GW_RD:    state_next = ST_GW_CHK;
      ST_GW_CHK: begin
        if (!child_none || w == '0) begin
          state_next = mode_search ? ST_CH_TEST : ST_RB_NEXT;
        end else begin
          state_next = ST_GW_RD;
        end
      end
      ST_SR_START: state_next = ST_GW_RD;
      ST_CH_TEST:  state_next = (cv == '0) ? ST_IDLE : ST_CH_CHK;
      ST_CH_CHK:   state_next = rd_term ? ST_IDLE : ST_CH_TEST;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Memory addresses and write enables.
  always_comb begin
    ch_we    = 1'b0;
    ch_waddr = {ins_v, sym_r};
    ch_wdata = vcount[VB-1:0];
    ch_raddr = {w, c};
    vi_we    = 1'b0;
    vi_waddr = new_v;
    vi_wdata = {new_d, ins_v, sym_r, pend_r, pcount_inc};
    vi_raddr = v;
    sf_we    = 1'b0;
    sf_waddr = v;
    sf_wdata = '0;
    sf_raddr = w;
    case (state)
      ST_CLEAR: begin
        ch_we    = 1'b1;
        ch_waddr = clr_addr;
        ch_wdata = '0;
      end
      ST_INS_RD: ch_raddr = {ins_v, sym_r};
      ST_INS_DO: begin
        if (child_none && !table_over) begin
          ch_we = 1'b1;
          vi_we = 1'b1;
        end else if (!child_none && pend_r) begin
          vi_we = 1'b1;
        end
      end
      ST_RB_CHK: begin
        sf_raddr = rd_parent;
        if (rd_depth == d && rd_parent == '0) sf_we = 1'b1;
      end
      ST_GW_CHK: begin
        sf_wdata = gw_res;
        if (!mode_search && (!child_none || w == '0)) sf_we = 1'b1;
      end
      ST_CH_TEST: begin
        vi_raddr = cv;
        sf_raddr = cv;
      end
      default: ;
    endcase
  end

  // Control and architectural registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      vcount     <= (VB+1)'(1);
      pcount     <= '0;
      ins_v      <= '0;
      ins_d      <= '0;
      max_depth  <= '0;
      sv         <= '0;
      pos        <= '0;
      memo_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        ST_CLEAR: clr_addr <= clr_addr + CAW'(1);
        ST_IDLE: begin
          if (accept) begin
            sym_r    <= symbol[SB-1:0];
            pend_r   <= pattern_end;
            tstart_r <= text_start;
            if (command == CMD_INSERT) memo_valid <= 1'b0;
          end
        end
        ST_INS_DO: begin
          out_valid      <= 1'b1;
          match_found    <= 1'b0;
          match_start    <= '0;
          pattern_number <= '0;
          table_full     <= 1'b0;
          if (child_none && table_over) begin
            table_full <= 1'b1;
            if (pend_r) begin
              ins_v <= '0;
              ins_d <= '0;
            end
          end else begin
            if (child_none) begin
              vcount <= vcount + (VB+1)'(1);
              if (new_d > max_depth) max_depth <= new_d;
            end
            if (pend_r) begin
              pcount <= pcount_inc;
              ins_v  <= '0;
              ins_d  <= '0;
            end else begin
              ins_v <= new_v;
              ins_d <= new_d;
            end
          end
        end
        ST_RB_START: begin
          d <= VB'(1);
          v <= VB'(1);
          if (max_depth == '0) memo_valid <= 1'b1;
        end
        ST_RB_CHK: begin
          c           <= rd_psym;
          mode_search <= 1'b0;
        end
        ST_RB_PAR: w <= sf_rdata;
        ST_RB_NEXT: begin
          if ((VB+1)'(v) + (VB+1)'(1) == vcount) begin
            v <= VB'(1);
            d <= d + VB'(1);
            if (d == max_depth) memo_valid <= 1'b1;
          end else begin
            v <= v + VB'(1);
          end
        end
        ST_GW_CHK: begin
          if (!child_none || w == '0) begin
            if (mode_search) begin
              sv <= gw_res;
              cv <= gw_res;
            end
          end else begin
            w <= sf_rdata;
          end
        end
        ST_SR_START: begin
          c           <= sym_r;
          mode_search <= 1'b1;
          if (tstart_r) begin
            pos <= PB'(1);
            w   <= '0;
          end else begin
            pos <= pos + PB'(1);
            w   <= sv;
          end
        end
        ST_CH_TEST: begin
          if (cv == '0) begin
            out_valid      <= 1'b1;
            match_found    <= 1'b0;
            match_start    <= '0;
            pattern_number <= '0;
            table_full     <= 1'b0;
          end
        end
        ST_CH_CHK: begin
          if (rd_term) begin
            out_valid      <= 1'b1;
            match_found    <= 1'b1;
            match_start    <= start_ext[31:0];
            pattern_number <= rd_num;
            table_full     <= 1'b0;
          end else begin
            cv <= sf_rdata;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/mpsm_checker.sv =====
`include "multi_pattern_string_matcher_unit_assert.svh"

module mpsm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        match_found,
  input logic [31:0] match_start,
  input logic [7:0]  pattern_number,
  input logic        table_full
);

  // A waiting result holds until it is taken.
  `MPSM_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(match_start) && $stable(pattern_number))

  // No new transaction is taken while a result waits.
  `MPSM_ASSERT(a_no_accept_busy, clk, rst, out_valid |-> !in_ready)

  // A failed insert reports no match.
  `MPSM_ASSERT(a_full_no_match, clk, rst, out_valid && table_full |-> !match_found && pattern_number == 8'd0)

  // A match always names a pattern; no match carries zero fields.
  `MPSM_ASSERT(a_match_fields, clk, rst, out_valid |-> (match_found == (pattern_number != 8'd0)) && (match_found || match_start == 32'd0))

endmodule

bind multi_pattern_string_matcher_unit mpsm_checker u_mpsm_checker (.*);
